/* sv/cvdm_pkg.sv */
// shared types and constants for the charge voltage drop monitor
// item structs, configuration defaults and the constant-divide reciprocal
// no dependencies
`default_nettype none

package cvdm_pkg;

  localparam int TICK_W  = 16;
  localparam int VS_W    = 23;
  localparam int RATIO_W = 7;
  localparam int CFG_IDX_W = 1;

  // samples averaged into the baseline and into the current level
  localparam int AVG_SAMPLES = 10;

  // percent scale of the drop ratio
  localparam int PCT_SCALE = 100;
  localparam int CMP_W     = VS_W + RATIO_W;

  localparam logic [VS_W-1:0] SUM_MAX = {VS_W{1'b1}};

  // exact divide by AVG_SAMPLES for any VS_W-bit value: q = (x * m) >> shift
  localparam int DIV_SHIFT = VS_W + $clog2(AVG_SAMPLES);
  localparam int PROD_W    = 2 * VS_W + 1;
  localparam logic [VS_W:0] DIV_MULT =
    (VS_W+1)'(((64'd1 << DIV_SHIFT) / 64'(AVG_SAMPLES)) + 64'd1);

  localparam logic [TICK_W-1:0]  DETECT_PERIOD_RST = 16'd1800;
  localparam logic [RATIO_W-1:0] DROP_RATIO_RST    = 7'd85;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_RATIO    = 1'd1;

  typedef struct packed {
    logic            charging;
    logic [VS_W-1:0] voltage_sample;
    logic            reconnect_busy;
  } in_item_t;

  typedef struct packed {
    logic reconnect_request;
    logic period_done;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]  detect_period;
    logic [RATIO_W-1:0] drop_ratio_percent;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/cvdm_track.sv */
// period tracking state and per-tick update of the drop monitor
// holds tick count, both window sums and the reference level
// depends on cvdm_pkg
`default_nettype none

module cvdm_track (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire cvdm_pkg::in_item_t item,
  input  wire cvdm_pkg::cfg_t     cfg,
  output cvdm_pkg::out_item_t     res
);

  logic [cvdm_pkg::TICK_W-1:0] tick_count_r, tick_count_nxt;
  logic [cvdm_pkg::VS_W-1:0]   baseline_r, baseline_nxt;
  logic [cvdm_pkg::VS_W-1:0]   current_r, current_nxt;
  logic [cvdm_pkg::VS_W-1:0]   reference_r, reference_nxt;

  logic [cvdm_pkg::TICK_W:0]   next_cnt;
  logic [cvdm_pkg::TICK_W:0]   win_end;
  logic [cvdm_pkg::TICK_W:0]   period_x;
  logic [cvdm_pkg::PROD_W-1:0] div_prod;
  logic [cvdm_pkg::VS_W-1:0]   part;
  logic [cvdm_pkg::VS_W:0]     base_add;
  logic [cvdm_pkg::VS_W:0]     cur_add;
  logic [cvdm_pkg::VS_W-1:0]   base_sat;
  logic [cvdm_pkg::VS_W-1:0]   cur_sat;
  logic [cvdm_pkg::VS_W-1:0]   ref_eff;
  logic [cvdm_pkg::CMP_W-1:0]  lhs;
  logic [cvdm_pkg::CMP_W-1:0]  rhs;
  logic                        drop;

  always_comb begin
    next_cnt = {1'b0, tick_count_r} + (cvdm_pkg::TICK_W+1)'(1);
    win_end  = next_cnt + (cvdm_pkg::TICK_W+1)'(cvdm_pkg::AVG_SAMPLES);
    period_x = {1'b0, cfg.detect_period};

    div_prod = cvdm_pkg::PROD_W'(item.voltage_sample) * cvdm_pkg::PROD_W'(cvdm_pkg::DIV_MULT);
    part     = cvdm_pkg::VS_W'(div_prod >> cvdm_pkg::DIV_SHIFT);

    base_add = {1'b0, baseline_r} + {1'b0, part};
    cur_add  = {1'b0, current_r} + {1'b0, part};
    base_sat = base_add[cvdm_pkg::VS_W] ? cvdm_pkg::SUM_MAX : base_add[cvdm_pkg::VS_W-1:0];
    cur_sat  = cur_add[cvdm_pkg::VS_W] ? cvdm_pkg::SUM_MAX : cur_add[cvdm_pkg::VS_W-1:0];

    // reference is seeded from the baseline on the first closing tick
    ref_eff = (reference_r == '0) ? baseline_r : reference_r;
    lhs     = cvdm_pkg::CMP_W'(current_r) * cvdm_pkg::CMP_W'(cvdm_pkg::PCT_SCALE);
    rhs     = cvdm_pkg::CMP_W'(cfg.drop_ratio_percent) * cvdm_pkg::CMP_W'(ref_eff);
    drop    = lhs < rhs;

    tick_count_nxt = tick_count_r;
    baseline_nxt   = baseline_r;
    current_nxt    = current_r;
    reference_nxt  = reference_r;
    res            = '0;

    if (!item.charging) begin
      tick_count_nxt = '0;
      baseline_nxt   = '0;
      current_nxt    = '0;
      reference_nxt  = '0;
    end else if (!item.reconnect_busy) begin
      if (next_cnt <= (cvdm_pkg::TICK_W+1)'(cvdm_pkg::AVG_SAMPLES)) begin
        baseline_nxt   = base_sat;
        tick_count_nxt = next_cnt[cvdm_pkg::TICK_W-1:0];
      end else if (win_end > period_x && next_cnt <= period_x) begin
        current_nxt    = cur_sat;
        tick_count_nxt = next_cnt[cvdm_pkg::TICK_W-1:0];
      end else if (next_cnt > period_x) begin
        res.period_done       = 1'b1;
        res.reconnect_request = drop;
        if (!drop && current_r > ref_eff) begin
          reference_nxt = current_r;
        end else begin
          reference_nxt = ref_eff;
        end
        baseline_nxt   = '0;
        current_nxt    = '0;
        tick_count_nxt = '0;
      end else begin
        tick_count_nxt = next_cnt[cvdm_pkg::TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      baseline_r   <= '0;
      current_r    <= '0;
      reference_r  <= '0;
    end else if (adv) begin
      tick_count_r <= tick_count_nxt;
      baseline_r   <= baseline_nxt;
      current_r    <= current_nxt;
      reference_r  <= reference_nxt;
    end
  end

  // leaving charge drops the whole history, reference included
  a_clear_on_discharge: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !item.charging |=> tick_count_r == '0 && reference_r == '0 && baseline_r == '0)
    else $error("state not cleared after a non-charging item");

  // a closed period restarts both windows and the counter
  a_restart_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.period_done |=> tick_count_r == '0 && current_r == '0 && baseline_r == '0)
    else $error("period close did not restart the windows");

  // a busy tick while charging leaves the counter and reference alone
  a_hold_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.charging && item.reconnect_busy |=>
      $stable(tick_count_r) && $stable(reference_r))
    else $error("state changed on a busy item");

endmodule

`default_nettype wire

/* sv/charge_voltage_drop_monitor.sv */
// an accepted item passes the input register, then the result register; throughput: one item
// per cycle while out_stall is low; the per-tick state update is a single pass of logic
// between the input register and the result register, bounded by the ratio multiply and compare
// reset (rst_n low, synchronous): both item registers empty, tick count, sums and reference
// cleared, detect_period back to 1800 and drop_ratio_percent back to 85
// depends on cvdm_pkg and cvdm_track
`default_nettype none

module charge_voltage_drop_monitor (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input items, one per one-second tick
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire cvdm_pkg::in_item_t                  in_item,
  // result items, exactly one per input item
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output cvdm_pkg::out_item_t                      out_item,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cvdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cvdm_pkg::TICK_W-1:0]         cfg_data
);

  // configuration registers
  cvdm_pkg::cfg_t cfg_r;

  // input register stage
  logic               s1_valid_r;
  cvdm_pkg::in_item_t s1_item_r;

  // result register stage
  logic                out_valid_r;
  cvdm_pkg::out_item_t out_item_r;

  cvdm_pkg::out_item_t step_res;
  logic                move;
  logic                in_take;

  // the item in the input register moves on when the result register is free
  // or is being emptied in the same cycle; the state update happens on that move
  assign move     = s1_valid_r && (!out_valid_r || !out_stall);
  // the input register refills whenever it is empty or draining
  assign in_stall = s1_valid_r && !move;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // writes must only happen while idle; the block does not enforce this, and the port always takes them
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_period      <= cvdm_pkg::DETECT_PERIOD_RST;
      cfg_r.drop_ratio_percent <= cvdm_pkg::DROP_RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cvdm_pkg::CFG_DETECT_PERIOD: begin
          cfg_r.detect_period <= cfg_data;
        end
        cvdm_pkg::CFG_DROP_RATIO: begin
          cfg_r.drop_ratio_percent <= cfg_data[cvdm_pkg::RATIO_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload holds while stalled, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  // per-tick tracking: windows, reference and the drop decision
  cvdm_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (move),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_item_r <= step_res;
    end
  end

  // a request is only ever raised on a period-closing tick
  a_request_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.reconnect_request && !out_item_r.period_done))
    else $error("reconnect request outside a period close");

  // an empty result register never holds back the input register
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |-> move)
    else $error("item held with an empty result register");

  // every item moved on shows up as a result in the next cycle
  a_move_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("moved item produced no result");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for charge_voltage_drop_monitor
// holds its own per-tick drop predictor and a result scoreboard in one class
// depends on cvdm_pkg and the monitor rtl
`timescale 1ns / 1ps

module tb_top;
  import cvdm_pkg::*;

  // generous bound, many times the slowest run under the heaviest stall pattern
  localparam longint CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 300;

  // predicts the two result flags of each tick and checks results in order
  class drop_tracker;
    logic [TICK_W-1:0]  det_period;
    logic [RATIO_W-1:0] ratio;
    logic [TICK_W-1:0]  tick_cnt;
    logic [VS_W-1:0]    base_sum;
    logic [VS_W-1:0]    cur_sum;
    logic [VS_W-1:0]    ref_lvl;
    out_item_t          due_flags[$];
    int                 n_mismatch;

    function new();
      det_period = DETECT_PERIOD_RST;
      ratio      = DROP_RATIO_RST;
      tick_cnt   = '0;
      base_sum   = '0;
      cur_sum    = '0;
      ref_lvl    = '0;
      n_mismatch = 0;
    endfunction

    function logic [VS_W-1:0] sat_add(logic [VS_W-1:0] a, logic [VS_W-1:0] b);
      logic [VS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[VS_W-1:0];
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
      if (idx == CFG_DETECT_PERIOD) begin
        det_period = val;
      end else if (idx == CFG_DROP_RATIO) begin
        ratio = val[RATIO_W-1:0];
      end
    endfunction

    function void note_tick(in_item_t it);
      int               nxt;
      logic [VS_W-1:0]  part;
      logic [CMP_W-1:0] lhs;
      logic [CMP_W-1:0] rhs;
      out_item_t        res;
      res = '0;
      if (!it.charging) begin
        tick_cnt = '0;
        base_sum = '0;
        cur_sum  = '0;
        ref_lvl  = '0;
      end else if (!it.reconnect_busy) begin
        nxt  = int'(tick_cnt) + 1;
        part = VS_W'(it.voltage_sample / AVG_SAMPLES);
        if (nxt <= AVG_SAMPLES) begin
          base_sum = sat_add(base_sum, part);
          tick_cnt = TICK_W'(nxt);
        end else if (nxt + AVG_SAMPLES > int'(det_period) && nxt <= int'(det_period)) begin
          cur_sum  = sat_add(cur_sum, part);
          tick_cnt = TICK_W'(nxt);
        end else if (nxt > int'(det_period)) begin
          res.period_done = 1'b1;
          if (ref_lvl == '0) begin
            ref_lvl = base_sum;
          end
          lhs = CMP_W'(cur_sum) * CMP_W'(PCT_SCALE);
          rhs = CMP_W'(ratio) * CMP_W'(ref_lvl);
          if (lhs < rhs) begin
            res.reconnect_request = 1'b1;
          end else if (cur_sum > ref_lvl) begin
            ref_lvl = cur_sum;
          end
          base_sum = '0;
          cur_sum  = '0;
          tick_cnt = '0;
        end else begin
          tick_cnt = TICK_W'(nxt);
        end
      end
      due_flags.push_back(res);
    endfunction

    function void flag(string msg);
      if (n_mismatch < 10) begin
        $display("mismatch at %0t: %s", $time, msg);
      end
      n_mismatch++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_flags.size() == 0) begin
        flag($sformatf("result %b with no item outstanding", got));
        return;
      end
      want = due_flags.pop_front();
      if (got.reconnect_request !== want.reconnect_request) begin
        flag($sformatf("reconnect_request expected %b got %b",
                       want.reconnect_request, got.reconnect_request));
      end
      if (got.period_done !== want.period_done) begin
        flag($sformatf("period_done expected %b got %b", want.period_done, got.period_done));
      end
    endfunction
  endclass

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // every block input starts at a known value
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DETECT_PERIOD;
  logic [TICK_W-1:0]    cfg_data = '0;

  drop_tracker  tracker = new();
  longint       cycle_cnt = 0;
  stall_mode_t  stall_mode = STALL_NONE;
  int           stall_left = 0;
  logic [VS_W-1:0] batt_level = VS_W'(4200000);
  in_item_t     plan[$];

  charge_voltage_drop_monitor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side stalls on its own pattern; the mode is redrawn whenever a random countdown runs out,
  // so some stretches never stall and others stall most of the time
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
      default:     out_stall <= (cycle_cnt[2:0] < 3'd2);
    endcase
  end

  // every accepted result is compared with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_result(out_item);
    end
  end

  function automatic in_item_t tick(logic chg, logic [VS_W-1:0] uv, logic busy);
    in_item_t it;
    it.charging       = chg;
    it.voltage_sample = uv;
    it.reconnect_busy = busy;
    return it;
  endfunction

  // random tick around a drifting battery level; drops below the reference are
  // frequent enough that requests show up, full-range jumps exercise every bit
  function automatic in_item_t make_tick(bit steady);
    in_item_t it;
    int       r;
    it.charging       = steady ? 1'b1 : ($urandom_range(0, 149) != 0);
    it.reconnect_busy = steady ? ($urandom_range(0, 99) == 0) : ($urandom_range(0, 11) == 0);
    r = $urandom_range(0, 99);
    if (r < 3) begin
      batt_level = VS_W'($urandom);
    end else if (r < 8) begin
      batt_level = VS_W'(int'(batt_level) * (100 - $urandom_range(5, 40)) / 100);
    end else if (r < 10) begin
      batt_level = batt_level + (SUM_MAX - batt_level) / 4;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      it.voltage_sample = '0;
    end else if (r < 4) begin
      it.voltage_sample = SUM_MAX;
    end else if (r < 8) begin
      it.voltage_sample = VS_W'($urandom);
    end else begin
      it.voltage_sample = batt_level ^ VS_W'($urandom_range(0, 1023));
    end
    return it;
  endfunction

  // holds the item until the block takes it, then notes it for prediction
  task automatic drive_item(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_tick(it);
  endtask

  // waits until every predicted result has come back
  task automatic wait_settled();
    while (tracker.due_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it once the last write is done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  // only called with the block idle; upper ratio data bits are don't-care and get noise
  task automatic set_config(input logic [TICK_W-1:0] period, input int pct);
    write_reg(CFG_DETECT_PERIOD, period);
    write_reg(CFG_DROP_RATIO,
              (TICK_W'($urandom_range(0, 511)) << RATIO_W) | TICK_W'(pct));
    cfg_valid <= 1'b0;
  endtask

  // directed items back to back
  task automatic send_plan();
    foreach (plan[k]) begin
      drive_item(plan[k]);
    end
    in_valid <= 1'b0;
    plan.delete();
  endtask

  // random items in bursts; now and then the sender holds off until all results are in
  task automatic send_run(input int n, input bit steady, input bit gaps);
    int burst;
    burst = $urandom_range(1, 24);
    for (int k = 0; k < n; k++) begin
      drive_item(make_tick(steady));
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (gaps) begin
          in_valid <= 1'b0;
          if ($urandom_range(0, 39) == 0) begin
            wait_settled();
          end else begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
        end
      end
    end
    if (in_valid) in_valid <= 1'b0;
  endtask

  initial begin
    int n;
    int r;
    int sent;
    int pct;
    logic [TICK_W-1:0] period;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: full-scale sample, busy tick, then not charging clears everything
    plan.push_back(tick(1'b1, SUM_MAX, 1'b0));
    plan.push_back(tick(1'b1, '0, 1'b1));
    plan.push_back(tick(1'b0, SUM_MAX, 1'b1));
    send_plan();

    // zero period: only the baseline fills, the current-level window stays empty, and the period closes
    // on tick 11; ratio zero never requests, full ratio then sees the level fall to 0
    wait_settled();
    set_config('0, 0);
    for (int k = 0; k < 10; k++) plan.push_back(tick(1'b1, SUM_MAX, k == 4));
    plan.push_back(tick(1'b1, SUM_MAX, 1'b0));
    plan.push_back(tick(1'b1, SUM_MAX, 1'b0));
    send_plan();
    wait_settled();
    set_config('0, 100);
    for (int k = 0; k < 11; k++) plan.push_back(tick(1'b1, '0, 1'b0));
    send_plan();

    // period stretched while inside the current-level window: 15 samples, sum saturates
    wait_settled();
    set_config(TICK_W'(100), 1);
    for (int k = 0; k < 95; k++) plan.push_back(tick(1'b1, SUM_MAX, 1'b0));
    send_plan();
    wait_settled();
    set_config(TICK_W'(105), 1);
    for (int k = 0; k < 11; k++) plan.push_back(tick(1'b1, SUM_MAX, 1'b0));
    send_plan();

    // random phases, mostly short periods so many periods close
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n = $urandom_range(40, 120);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        period = TICK_W'($urandom_range(0, 19));
      end else if (r == 1) begin
        period = TICK_W'(20);
      end else if (r < 9) begin
        period = TICK_W'($urandom_range(20, 48));
      end else begin
        period = TICK_W'($urandom_range(49, 150));
      end
      r = $urandom_range(0, 9);
      if (r == 0) begin
        pct = 1;
      end else if (r == 1) begin
        pct = 100;
      end else if (r == 2) begin
        pct = 0;
      end else if (r == 3) begin
        pct = $urandom_range(101, 127);
      end else begin
        pct = $urandom_range(60, 99);
      end
      wait_settled();
      set_config(period, pct);
      send_run(n, 1'b0, 1'b1);
      sent += n;
    end

    // largest period: the full-width compare must keep the period open
    wait_settled();
    set_config(16'hFFFF, $urandom_range(1, 100));
    send_run(80, 1'b1, 1'b0);

    wait_settled();
    repeat (8) @(posedge clk);
    if (tracker.n_mismatch == 0 && tracker.due_flags.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
